### hdl/assert_macros.svh
// Concurrent assertion helpers, clocked on the rising edge and off while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define NSTB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define NSTB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define NSTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/nstb_pkg.sv
package nstb_pkg;

  localparam int unsigned OUT_BITS = 8;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_ZERO   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_BIN = 2'd2
  } radix_e;

  typedef struct packed {
    phase_e phase;
    radix_e radix;
    logic   failed;
  } state_t;

  localparam state_t ST_RESET = '{phase: PH_SKIP, radix: RX_DEC, failed: 1'b0};

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic                ok;
    logic [OUT_BITS-1:0] value;
  } out_t;

endpackage

### hdl/nstb_step.sv
module nstb_step #(
  parameter int unsigned VALUE_BITS = 8
) (
  input  nstb_pkg::state_t        st_i,
  input  logic [VALUE_BITS-1:0]   accum_i,
  input  nstb_pkg::in_t           item_i,
  output nstb_pkg::state_t        st_o,
  output logic [VALUE_BITS-1:0]   accum_o,
  output nstb_pkg::out_t          res_o
);

  logic [7:0]              c;
  logic                    take;
  logic                    clr_acc;
  logic                    fail_pre;
  nstb_pkg::phase_e        ph_pre;
  nstb_pkg::radix_e        rx_use;
  logic [3:0]              digit;
  logic                    is_hexch;
  logic                    digit_ok;
  logic [VALUE_BITS-1:0]   acc_src;
  logic [VALUE_BITS+3:0]   scaled;
  logic [VALUE_BITS+3:0]   sum;
  logic                    ovf;
  nstb_pkg::state_t        st_n;
  logic [VALUE_BITS-1:0]   acc_n;

  assign c = item_i.character;

  // prefix and whitespace handling
  always_comb begin
    take     = 1'b0;
    clr_acc  = 1'b0;
    fail_pre = st_i.failed;
    ph_pre   = st_i.phase;
    rx_use   = st_i.radix;
    if (!st_i.failed) begin
      case (st_i.phase)
        nstb_pkg::PH_SKIP: begin
          if (c == nstb_pkg::CH_SPACE || c == nstb_pkg::CH_TAB) begin
            fail_pre = item_i.last_char;
          end else if (c == nstb_pkg::CH_ZERO && !item_i.last_char) begin
            ph_pre = nstb_pkg::PH_ZERO;
          end else begin
            rx_use = nstb_pkg::RX_DEC;
            take   = 1'b1;
          end
        end
        nstb_pkg::PH_ZERO: begin
          if (c == nstb_pkg::CH_LX || c == nstb_pkg::CH_UX) begin
            rx_use   = nstb_pkg::RX_HEX;
            ph_pre   = nstb_pkg::PH_DIGITS;
            fail_pre = item_i.last_char;
          end else if (c == nstb_pkg::CH_LB || c == nstb_pkg::CH_UB) begin
            rx_use   = nstb_pkg::RX_BIN;
            ph_pre   = nstb_pkg::PH_DIGITS;
            fail_pre = item_i.last_char;
          end else begin
            rx_use  = nstb_pkg::RX_DEC;
            clr_acc = 1'b1;
            take    = 1'b1;
          end
        end
        default: begin
          take = 1'b1;
        end
      endcase
    end
  end

  // digit decode and accumulate
  always_comb begin
    digit    = '0;
    is_hexch = 1'b0;
    if (c inside {[nstb_pkg::CH_ZERO:nstb_pkg::CH_NINE]}) begin
      digit    = 4'(c - nstb_pkg::CH_ZERO);
      is_hexch = 1'b1;
    end else if (c inside {[nstb_pkg::CH_LA:nstb_pkg::CH_LF]}) begin
      digit    = 4'(c - nstb_pkg::CH_LA) + 4'd10;
      is_hexch = 1'b1;
    end else if (c inside {[nstb_pkg::CH_UA:nstb_pkg::CH_UF]}) begin
      digit    = 4'(c - nstb_pkg::CH_UA) + 4'd10;
      is_hexch = 1'b1;
    end

    acc_src = clr_acc ? '0 : accum_i;

    case (rx_use)
      nstb_pkg::RX_HEX: begin
        digit_ok = is_hexch;
        scaled   = {acc_src, 4'b0000};
      end
      nstb_pkg::RX_BIN: begin
        digit_ok = is_hexch && (digit < 4'd2);
        scaled   = {3'b000, acc_src, 1'b0};
      end
      default: begin
        digit_ok = is_hexch && (digit < 4'd10);
        scaled   = {1'b0, acc_src, 3'b000} + {3'b000, acc_src, 1'b0};
      end
    endcase

    sum = scaled + (VALUE_BITS+4)'(digit);
    ovf = |sum[VALUE_BITS+3:VALUE_BITS];
  end

  // next state
  always_comb begin
    st_n.phase  = take ? nstb_pkg::PH_DIGITS : ph_pre;
    st_n.radix  = rx_use;
    st_n.failed = fail_pre | (take & (~digit_ok | ovf));
    acc_n       = (take && digit_ok && !ovf) ? sum[VALUE_BITS-1:0] : acc_src;
    if (item_i.last_char) begin
      st_o    = nstb_pkg::ST_RESET;
      accum_o = '0;
    end else begin
      st_o    = st_n;
      accum_o = acc_n;
    end
  end

  // result
  always_comb begin
    res_o.ok    = ~st_n.failed;
    res_o.value = st_n.failed ? '0 : acc_n[nstb_pkg::OUT_BITS-1:0];
  end

endmodule

### hdl/numeric_string_to_byte.sv
// Throughput: one character per cycle; the input stalls only while a result is held.
// One input register, one combinational update of phase/radix/accumulator, one result register.
// Reset (rst_ni, async, active low) empties both registers and returns to whitespace skipping.
module numeric_string_to_byte #(
  parameter int unsigned VALUE_BITS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  nstb_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output nstb_pkg::out_t out_data_o
);

  nstb_pkg::in_t          in_q;
  logic                   in_valid_q;
  nstb_pkg::state_t       st_q;
  nstb_pkg::state_t       st_d;
  logic [VALUE_BITS-1:0]  accum_q;
  logic [VALUE_BITS-1:0]  accum_d;
  nstb_pkg::out_t         res;
  nstb_pkg::out_t         out_q;
  logic                   out_valid_q;
  logic                   slot_free;
  logic                   advance;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!in_q.last_char || slot_free);
  assign in_ready_o = !in_valid_q || advance;

  nstb_step #(
    .VALUE_BITS(VALUE_BITS)
  ) u_step (
    .st_i    (st_q),
    .accum_i (accum_q),
    .item_i  (in_q),
    .st_o    (st_d),
    .accum_o (accum_d),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= nstb_pkg::ST_RESET;
      accum_q <= '0;
    end else if (advance) begin
      st_q    <= st_d;
      accum_q <= accum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_q.last_char) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_q.last_char) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hdl/nstb_checker.sv
`include "assert_macros.svh"

module nstb_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input nstb_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input nstb_pkg::out_t out_data_o
);

  `NSTB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result changed before transfer")

  `NSTB_ASSERT_IMPL(a_fail_zero, clk_i, rst_ni, out_valid_o && !out_data_o.ok, out_data_o.value == '0, "failed result carries a value")

  `NSTB_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i, "input stalled with no result held")

  `NSTB_ASSERT_IMPL(a_result_src, clk_i, rst_ni, $rose(out_valid_o), $past(in_valid_i && in_ready_o && in_data_i.last_char, 2), "result without a final character")

endmodule

bind numeric_string_to_byte nstb_checker u_nstb_checker (.*);

### tb/numeric_string_to_byte_checker.sv
`timescale 1ns / 100ps

module numeric_string_to_byte_checker
  import nstb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_data_i,
  output int   err_count_o,
  output int   outstanding_o,
  output int   checked_o,
  output int   ok_count_o
);

  localparam int unsigned VALUE_MAX = (1 << OUT_BITS) - 1;

  phase_e              cur_phase = PH_SKIP;
  radix_e              cur_radix = RX_DEC;
  logic [OUT_BITS-1:0] acc       = '0;
  logic                failed    = 1'b0;
  out_t                conversions[$];

  function automatic int unsigned base_of(radix_e r);
    case (r)
      RX_HEX:  return 16;
      RX_BIN:  return 2;
      default: return 10;
    endcase
  endfunction

  task automatic add_digit(input logic [7:0] c);
    int unsigned d;
    int unsigned b;
    b = base_of(cur_radix);
    cur_phase = PH_DIGITS;
    if (failed) return;
    if (c >= CH_ZERO && c <= CH_NINE) d = 32'(c - CH_ZERO);
    else if (c >= CH_LA && c <= CH_LF) d = c - CH_LA + 10;
    else if (c >= CH_UA && c <= CH_UF) d = c - CH_UA + 10;
    else begin
      failed = 1'b1;
      return;
    end
    if (d >= b || int'(acc) > (VALUE_MAX - d) / b) begin
      failed = 1'b1;
      return;
    end
    acc = OUT_BITS'(acc * b + d);
  endtask

  task automatic convert_char(input in_t item);
    logic [7:0] c;
    logic       fin;
    out_t       r;
    c   = item.character;
    fin = item.last_char;
    if (!failed) begin
      case (cur_phase)
        PH_SKIP: begin
          if (c == CH_SPACE || c == CH_TAB) begin
            if (fin) failed = 1'b1;
          end else if (c == CH_ZERO && !fin) begin
            cur_phase = PH_ZERO;
          end else begin
            cur_radix = RX_DEC;
            add_digit(c);
          end
        end
        PH_ZERO: begin
          if (c == CH_LX || c == CH_UX) begin
            cur_radix = RX_HEX;
            cur_phase = PH_DIGITS;
            if (fin) failed = 1'b1;
          end else if (c == CH_LB || c == CH_UB) begin
            cur_radix = RX_BIN;
            cur_phase = PH_DIGITS;
            if (fin) failed = 1'b1;
          end else begin
            cur_radix = RX_DEC;
            acc = '0;
            add_digit(c);
          end
        end
        default: add_digit(c);
      endcase
    end
    if (fin) begin
      r.ok    = !failed;
      r.value = failed ? '0 : acc;
      conversions.push_back(r);
      cur_phase = PH_SKIP;
      cur_radix = RX_DEC;
      acc       = '0;
      failed    = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (!rst_ni) begin
      err_count_o   <= 0;
      outstanding_o <= 0;
      checked_o     <= 0;
      ok_count_o    <= 0;
    end else begin
      if (in_valid_i && in_ready_i) convert_char(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (conversions.size() == 0) begin
          $display("%0t: unexpected result, got ok=%0b value=0x%02h",
                   $time, out_data_i.ok, out_data_i.value);
          err_count_o <= err_count_o + 1;
        end else begin
          want = conversions.pop_front();
          if (out_data_i.ok !== want.ok)
            $display("%0t: ok mismatch, expected %0b, got %0b",
                     $time, want.ok, out_data_i.ok);
          if (out_data_i.value !== want.value)
            $display("%0t: value mismatch, expected 0x%02h, got 0x%02h",
                     $time, want.value, out_data_i.value);
          if (out_data_i.ok !== want.ok || out_data_i.value !== want.value)
            err_count_o <= err_count_o + 1;
          checked_o  <= checked_o + 1;
          ok_count_o <= ok_count_o + int'(want.ok);
        end
      end
      outstanding_o <= conversions.size();
    end
  end

endmodule

### tb/tb_numeric_string_to_byte.sv
`timescale 1ns / 100ps

module tb_numeric_string_to_byte;
  import nstb_pkg::*;

  typedef logic [7:0] text_t[$];

  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_CHARS = 160;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  int err_count;
  int outstanding;
  int checked;
  int ok_count;

  int send_idle  = 0;
  int recv_stall = 0;
  int chars_sent = 0;
  bit hold_req   = 1'b0;

  always #5 clk_i = ~clk_i;

  numeric_string_to_byte dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  numeric_string_to_byte_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .err_count_o  (err_count),
    .outstanding_o(outstanding),
    .checked_o    (checked),
    .ok_count_o   (ok_count)
  );

  function automatic text_t text_of(string s);
    text_t t;
    t = {};
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  function automatic logic [7:0] digit_char(radix_e r);
    int unsigned d;
    case (r)
      RX_HEX:  d = $urandom_range(15);
      RX_BIN:  d = $urandom_range(1);
      default: d = $urandom_range(9);
    endcase
    if (d < 10) return CH_ZERO + 8'(d);
    return ($urandom_range(1) ? CH_UA : CH_LA) + 8'(d - 10);
  endfunction

  function automatic text_t random_text();
    text_t  s;
    radix_e r;
    int     k;
    int     n;
    s = {};
    k = $urandom_range(99);
    if (k < 12) begin
      // pure noise
      n = $urandom_range(1, 6);
      repeat (n) s.push_back(8'($urandom_range(255)));
      return s;
    end
    repeat ($urandom_range(2)) s.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
    case ($urandom_range(2))
      0:       r = RX_DEC;
      1:       r = RX_HEX;
      default: r = RX_BIN;
    endcase
    if (r == RX_HEX) begin
      s.push_back(CH_ZERO);
      s.push_back($urandom_range(1) ? CH_UX : CH_LX);
    end else if (r == RX_BIN) begin
      s.push_back(CH_ZERO);
      s.push_back($urandom_range(1) ? CH_UB : CH_LB);
    end else if ($urandom_range(3) == 0) begin
      s.push_back(CH_ZERO);
    end
    case (r)
      RX_BIN:  n = $urandom_range(0, 9);
      RX_HEX:  n = $urandom_range(0, 3);
      default: n = $urandom_range(0, 4);
    endcase
    repeat (n) s.push_back(digit_char(r));
    if (s.size() == 0) s.push_back(digit_char(RX_DEC));
    // broken strings: a corrupted character or trailing blank
    if (k < 25) s[$urandom_range(s.size() - 1)] = 8'($urandom_range(255));
    else if (k < 30) s.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
    return s;
  endfunction

  task automatic send_chars(input text_t s);
    foreach (s[i]) begin
      while ($urandom_range(99) < send_idle) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i  <= '{character: s[i], last_char: (i == s.size() - 1)};
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      chars_sent++;
    end
  endtask

  // receiver
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_numeric_string_to_byte: errors");
    $finish;
  end

  initial begin
    int target;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_chars(text_of(" "));
    send_chars(text_of("0x"));
    send_chars(text_of("0"));
    send_chars(text_of("07"));
    send_chars(text_of("255"));
    send_chars(text_of("256"));
    send_chars(text_of("0xFf"));
    send_chars(text_of("0b1"));
    send_chars(text_of("\t-"));
    send_chars('{8'hFF});
    send_chars('{8'h00});
    send_chars(text_of("0B2"));

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle  = 0;
          recv_stall = 0;
          hold_req   = 1'b1;
        end
        1: begin
          send_idle  = 63;
          recv_stall = 0;
        end
        2: begin
          send_idle  = 0;
          recv_stall = 63;
        end
        default: begin
          send_idle  = 15;
          recv_stall = 15;
        end
      endcase
      target = chars_sent + PHASE_CHARS;
      while (chars_sent < target) send_chars(random_text());
    end
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);

    $display("Sent %0d characters; %0d strings checked, %0d converted and %0d rejected,",
             chars_sent, checked, ok_count, checked - ok_count);
    $display("across idle, stall and long output hold-off phases.");
    if (err_count == 0) begin
      $display("tb_numeric_string_to_byte: clean");
    end else begin
      $display("tb_numeric_string_to_byte: errors");
    end
    $finish;
  end

endmodule
